### design/gated_constant_velocity_kalman_3d_assert.svh
// Assertion macros for the gated constant-velocity tracker.
`ifndef GATED_CONSTANT_VELOCITY_KALMAN_3D_ASSERT_SVH
`define GATED_CONSTANT_VELOCITY_KALMAN_3D_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GCVK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GCVK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/gcvk_pkg.sv
// Shared types, constants, microprogram and arithmetic helpers of the tracker.
`timescale 1ns / 1ps
package gcvk_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_BITS  = 32 + FRAC_BITS;
  localparam int ACC_W     = 36;

  localparam logic [2:0] REG_STEP_TIME   = 3'd0;
  localparam logic [2:0] REG_NOISE_XY    = 3'd1;
  localparam logic [2:0] REG_NOISE_Z     = 3'd2;
  localparam logic [2:0] REG_MEAS_NOISE  = 3'd3;
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd4;
  localparam logic [2:0] REG_PRED_TMO    = 3'd5;
  localparam logic [2:0] REG_RESET_TMO   = 3'd6;

  localparam logic [16:0] RST_STEP_TIME   = 17'd3277;
  localparam logic [24:0] RST_NOISE_XY    = 25'd262144;
  localparam logic [24:0] RST_NOISE_Z     = 25'd65536;
  localparam logic [24:0] RST_MEAS_NOISE  = 25'd6554;
  localparam logic [24:0] RST_SPEED_LIMIT = 25'd262144;
  localparam logic [15:0] RST_PRED_TMO    = 16'd2000;
  localparam logic [15:0] RST_RESET_TMO   = 16'd3000;

  localparam logic [1:0] LAST_AXIS = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_z;
    logic        [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] est_pos_x;
    logic signed [31:0] est_pos_y;
    logic signed [31:0] est_pos_z;
    logic signed [31:0] est_vel_x;
    logic signed [31:0] est_vel_y;
    logic signed [31:0] est_vel_z;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_PRE, ST_PRED, ST_UPD1, ST_DIVW,
    ST_GATE, ST_UPD2, ST_ACCEPT, ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    MUL_NONE, MUL_DT_DT, MUL_MQ_DT, MUL_DT_V, MUL_DT_PV, MUL_DT2_VV, MUL_Q_DT4,
    MUL_DT_VV, MUL_Q_DT3, MUL_Q_DT2, MUL_KV_E, MUL_NV_NV, MUL_SL_SL, MUL_KP_E,
    MUL_KV_PV, MUL_KP_PV, MUL_KP_PP
  } mul_sel_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_DT2, OP_DT3, OP_DT4, OP_POS_ADD, OP_ACC_PP2, OP_ACC_ADD, OP_PP_Q4,
    OP_ACC_PV, OP_PV_Q2, OP_VV_ADD, OP_KP_WR, OP_KV_WR, OP_NV_WR, OP_NORM_ADD,
    OP_NORM_CLR, OP_GATE, OP_POS_UPD, OP_VV_SUB, OP_PV_SUB, OP_PP_SUB, OP_ACCEPT,
    OP_RESET_TRK, OP_EMIT
  } acc_op_t;

  typedef struct packed {
    mul_sel_t mul;
    acc_op_t  op;
    logic     div_go;
    logic     div_pv;
  } uop_t;

  typedef struct packed {
    logic       latch;
    logic [1:0] axis;
    uop_t       uop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_meas;
    logic tick_go;
    logic meas_reset;
    logic gate_fail;
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
    if (x > 65'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -65'sh0_8000_0000) return -32'sh8000_0000;
    return x[31:0];
  endfunction

  // Fixed-point product: round half up, floor shift, saturate.
  function automatic logic signed [31:0] round_q(input logic signed [63:0] p);
    logic signed [64:0] s;
    s = 65'(p) + 65'sd32768;
    return sat32(s >>> FRAC_BITS);
  endfunction

  function automatic uop_t uop_for(input state_t st, input logic [2:0] sub);
    uop_t u;
    u = '{mul: MUL_NONE, op: OP_NONE, div_go: 1'b0, div_pv: 1'b0};
    case (st)
      ST_PRE: begin
        case (sub)
          3'd0: u.mul = MUL_DT_DT;
          3'd1: begin u.op = OP_DT2; u.mul = MUL_MQ_DT; end
          3'd2: begin u.op = OP_DT3; u.mul = MUL_MQ_DT; end
          3'd3: u.op = OP_DT4;
          default: ;
        endcase
      end
      ST_PRED: begin
        case (sub)
          3'd0: u.mul = MUL_DT_V;
          3'd1: begin u.op = OP_POS_ADD; u.mul = MUL_DT_PV; end
          3'd2: begin u.op = OP_ACC_PP2; u.mul = MUL_DT2_VV; end
          3'd3: begin u.op = OP_ACC_ADD; u.mul = MUL_Q_DT4; end
          3'd4: begin u.op = OP_PP_Q4; u.mul = MUL_DT_VV; end
          3'd5: begin u.op = OP_ACC_PV; u.mul = MUL_Q_DT3; end
          3'd6: begin u.op = OP_PV_Q2; u.mul = MUL_Q_DT2; end
          default: u.op = OP_VV_ADD;
        endcase
      end
      ST_UPD1: begin
        case (sub)
          3'd0: u.div_go = 1'b1;
          3'd1: u.op = OP_KP_WR;
          3'd2: begin u.div_go = 1'b1; u.div_pv = 1'b1; end
          3'd3: u.op = OP_KV_WR;
          3'd4: u.mul = MUL_KV_E;
          3'd5: u.op = OP_NV_WR;
          3'd6: u.mul = MUL_NV_NV;
          default: u.op = OP_NORM_ADD;
        endcase
      end
      ST_GATE: begin
        case (sub)
          3'd0: u.mul = MUL_SL_SL;
          3'd1: u.op = OP_GATE;
          default: ;
        endcase
      end
      ST_UPD2: begin
        case (sub)
          3'd0: u.mul = MUL_KP_E;
          3'd1: begin u.op = OP_POS_UPD; u.mul = MUL_KV_PV; end
          3'd2: begin u.op = OP_VV_SUB; u.mul = MUL_KP_PV; end
          3'd3: begin u.op = OP_PV_SUB; u.mul = MUL_KP_PP; end
          default: u.op = OP_PP_SUB;
        endcase
      end
      default: ;
    endcase
    return u;
  endfunction

endpackage

### design/gcvk_div.sv
// Restoring divider for the Kalman gains: one quotient bit per cycle.
`timescale 1ns / 1ps
module gcvk_div
  import gcvk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [32:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  logic                busy;
  logic                fin;
  logic [5:0]          cnt;
  logic [31:0]         rem;
  logic [DIV_BITS-1:0] dvd;
  logic [DIV_BITS-1:0] qmag;
  logic [31:0]         dsr;
  logic                neg;
  logic [32:0]         trial;
  logic                fits;
  logic [31:0]         num_mag;

  assign trial   = {rem, dvd[DIV_BITS-1]};
  assign fits    = trial >= {1'b0, dsr};
  assign num_mag = num[31] ? 32'(-num) : 32'(num);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den[32] || den == '0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= 6'(DIV_BITS - 1);
      rem  <= '0;
      dvd  <= {num_mag, {FRAC_BITS{1'b0}}};
      qmag <= '0;
      dsr  <= den[31:0];
      neg  <= num[31];
      quot <= '0;
    end else if (busy) begin
      cnt  <= cnt - 6'd1;
      dvd  <= {dvd[DIV_BITS-2:0], 1'b0};
      qmag <= {qmag[DIV_BITS-2:0], fits};
      rem  <= fits ? 32'(trial - {1'b0, dsr}) : trial[31:0];
    end else if (fin) begin
      // Truncating quotient, saturated to 32 bits.
      if (neg) begin
        quot <= (qmag > DIV_BITS'(33'h0_8000_0000)) ? -32'sh8000_0000 : -$signed(qmag[31:0]);
      end else begin
        quot <= (qmag > DIV_BITS'(33'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(qmag[31:0]);
      end
    end
  end

endmodule

### design/gcvk_datapath.sv
// Tracker datapath: state, configuration, shared multiplier, divider and result register.
`timescale 1ns / 1ps
module gcvk_datapath
  import gcvk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [24:0] cfg_data,
  input  in_item_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  input  logic       out_ready,
  output logic       out_valid,
  output out_item_t  out_data
);

  logic [16:0] step_time;
  logic [24:0] noise_xy, noise_z, meas_noise, speed_limit;
  logic [15:0] pred_tmo, reset_tmo;

  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] ppp [3];
  logic signed [31:0] ppv [3];
  logic signed [31:0] pvv [3];
  logic signed [31:0] kp [3];
  logic signed [31:0] kv [3];
  logic signed [31:0] err [3];
  logic signed [31:0] nv [3];
  logic signed [31:0] zin [3];
  logic [31:0]        last_time;
  logic               seen;
  logic               item_cmd;
  logic [31:0]        now;

  logic signed [31:0] dt2, dt3, dt4;
  logic signed [63:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic [63:0]        norm;
  logic               gate_fail;

  logic signed [31:0] mul_a, mul_b, mq, dt, qn, sl;
  logic [1:0]         ax;
  logic [31:0]        age;
  logic               div_done;
  logic signed [31:0] div_q;
  logic signed [32:0] den;

  assign ax  = cmd.axis;
  assign dt  = $signed({15'd0, step_time});
  assign qn  = $signed({7'd0, (ax == LAST_AXIS) ? noise_z : noise_xy});
  assign sl  = $signed({7'd0, speed_limit});
  assign mq  = round_q(prod);
  assign age = now - last_time;
  assign den = 33'(ppp[ax]) + $signed({8'd0, meas_noise});

  gcvk_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.uop.div_go),
    .num   (cmd.uop.div_pv ? ppv[ax] : ppp[ax]),
    .den   (den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.uop.mul)
      MUL_DT_DT:  begin mul_a = dt;      mul_b = dt;      end
      MUL_MQ_DT:  begin mul_a = mq;      mul_b = dt;      end
      MUL_DT_V:   begin mul_a = dt;      mul_b = vel[ax]; end
      MUL_DT_PV:  begin mul_a = dt;      mul_b = ppv[ax]; end
      MUL_DT2_VV: begin mul_a = dt2;     mul_b = pvv[ax]; end
      MUL_Q_DT4:  begin mul_a = qn;      mul_b = dt4;     end
      MUL_DT_VV:  begin mul_a = dt;      mul_b = pvv[ax]; end
      MUL_Q_DT3:  begin mul_a = qn;      mul_b = dt3;     end
      MUL_Q_DT2:  begin mul_a = qn;      mul_b = dt2;     end
      MUL_KV_E:   begin mul_a = kv[ax];  mul_b = err[ax]; end
      MUL_NV_NV:  begin mul_a = nv[ax];  mul_b = nv[ax];  end
      MUL_SL_SL:  begin mul_a = sl;      mul_b = sl;      end
      MUL_KP_E:   begin mul_a = kp[ax];  mul_b = err[ax]; end
      MUL_KV_PV:  begin mul_a = kv[ax];  mul_b = ppv[ax]; end
      MUL_KP_PV:  begin mul_a = kp[ax];  mul_b = ppv[ax]; end
      MUL_KP_PP:  begin mul_a = kp[ax];  mul_b = ppp[ax]; end
      default: ;
    endcase
  end

  always_comb begin
    status.is_meas    = item_cmd;
    status.tick_go    = seen && (age < {16'd0, pred_tmo});
    status.meas_reset = !seen || (age > {16'd0, reset_tmo});
    status.gate_fail  = gate_fail;
    status.div_done   = div_done;
    status.out_free   = !out_valid || out_ready;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time   <= RST_STEP_TIME;
      noise_xy    <= RST_NOISE_XY;
      noise_z     <= RST_NOISE_Z;
      meas_noise  <= RST_MEAS_NOISE;
      speed_limit <= RST_SPEED_LIMIT;
      pred_tmo    <= RST_PRED_TMO;
      reset_tmo   <= RST_RESET_TMO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_TIME:   step_time   <= cfg_data[16:0];
        REG_NOISE_XY:    noise_xy    <= cfg_data;
        REG_NOISE_Z:     noise_z     <= cfg_data;
        REG_MEAS_NOISE:  meas_noise  <= cfg_data;
        REG_SPEED_LIMIT: speed_limit <= cfg_data;
        REG_PRED_TMO:    pred_tmo    <= cfg_data[15:0];
        REG_RESET_TMO:   reset_tmo   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Latched request and scratch values.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_cmd <= in_data.cmd;
      zin[0]   <= in_data.meas_x;
      zin[1]   <= in_data.meas_y;
      zin[2]   <= in_data.meas_z;
      now      <= in_data.now_ms;
    end
    if (cmd.uop.mul != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    case (cmd.uop.op)
      OP_DT2:      dt2 <= mq;
      OP_DT3:      dt3 <= mq;
      OP_DT4:      dt4 <= mq;
      OP_ACC_PP2:  acc <= ACC_W'(ppp[ax]) + (ACC_W'(mq) <<< 1);
      OP_ACC_ADD:  acc <= acc + ACC_W'(mq);
      OP_ACC_PV:   acc <= ACC_W'(ppv[ax]) + ACC_W'(mq);
      OP_KP_WR:    kp[ax] <= div_q;
      OP_KV_WR: begin
        kv[ax]  <= div_q;
        err[ax] <= sat32(65'(zin[ax]) - 65'(pos[ax]));
      end
      OP_NV_WR:    nv[ax] <= sat32(65'(vel[ax]) + 65'(mq));
      OP_NORM_CLR: norm <= '0;
      OP_NORM_ADD: norm <= norm + $unsigned(prod);
      OP_GATE:     gate_fail <= norm > $unsigned(prod);
      default: ;
    endcase
  end

  // Track state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
        ppp[i] <= '0;
        ppv[i] <= '0;
        pvv[i] <= '0;
      end
      last_time <= '0;
      seen      <= 1'b0;
    end else begin
      case (cmd.uop.op)
        OP_POS_ADD: pos[ax] <= sat32(65'(pos[ax]) + 65'(mq));
        OP_PP_Q4:   ppp[ax] <= sat32(65'(acc) + ((65'(mq) + 65'sd2) >>> 2));
        OP_PV_Q2:   ppv[ax] <= sat32(65'(acc) + ((65'(mq) + 65'sd1) >>> 1));
        OP_VV_ADD:  pvv[ax] <= sat32(65'(pvv[ax]) + 65'(mq));
        OP_POS_UPD: begin
          pos[ax] <= sat32(65'(pos[ax]) + 65'(mq));
          vel[ax] <= nv[ax];
        end
        OP_VV_SUB:  pvv[ax] <= sat32(65'(pvv[ax]) - 65'(mq));
        OP_PV_SUB:  ppv[ax] <= sat32(65'(ppv[ax]) - 65'(mq));
        OP_PP_SUB:  ppp[ax] <= sat32(65'(ppp[ax]) - 65'(mq));
        OP_ACCEPT: begin
          last_time <= now;
          seen      <= 1'b1;
        end
        OP_RESET_TRK: begin
          for (int i = 0; i < 3; i++) begin
            pos[i] <= zin[i];
            vel[i] <= '0;
            ppp[i] <= '0;
            ppv[i] <= '0;
            pvv[i] <= '0;
          end
          last_time <= now;
          seen      <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.uop.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.uop.op == OP_EMIT) begin
      out_data <= '{est_pos_x: pos[0], est_pos_y: pos[1], est_pos_z: pos[2],
                    est_vel_x: vel[0], est_vel_y: vel[1], est_vel_z: vel[2]};
    end
  end

endmodule

### design/gcvk_ctrl.sv
// Tracker sequencer: walks the predict and update microprograms over the three axes.
`timescale 1ns / 1ps
module gcvk_ctrl
  import gcvk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t     state, state_next;
  logic [2:0] sub, sub_next;
  logic [1:0] axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sub   <= '0;
      axis  <= '0;
    end else begin
      state <= state_next;
      sub   <= sub_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    sub_next   = sub + 3'd1;
    axis_next  = axis;
    in_ready   = 1'b0;
    cmd.latch  = 1'b0;
    cmd.axis   = axis;
    cmd.uop    = uop_for(state, sub);
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        sub_next  = '0;
        axis_next = '0;
        if (in_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        sub_next = '0;
        if (status.is_meas && status.meas_reset) begin
          cmd.uop.op = OP_RESET_TRK;
          state_next = ST_IDLE;
        end else if (status.is_meas) begin
          cmd.uop.op = OP_NORM_CLR;
          state_next = ST_UPD1;
        end else if (status.tick_go) begin
          state_next = ST_PRE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PRE: begin
        if (sub == 3'd3) begin
          sub_next   = '0;
          state_next = ST_PRED;
        end
      end
      ST_PRED: begin
        if (sub == 3'd7) begin
          sub_next  = '0;
          axis_next = axis + 2'd1;
          if (axis == LAST_AXIS) begin
            axis_next  = '0;
            state_next = ST_EMIT;
          end
        end
      end
      ST_UPD1: begin
        if (cmd.uop.div_go) begin
          sub_next   = sub;
          state_next = ST_DIVW;
        end else if (sub == 3'd7) begin
          sub_next  = '0;
          axis_next = axis + 2'd1;
          if (axis == LAST_AXIS) begin
            axis_next  = '0;
            state_next = ST_GATE;
          end
        end
      end
      ST_DIVW: begin
        sub_next = sub;
        if (status.div_done) begin
          sub_next   = sub + 3'd1;
          state_next = ST_UPD1;
        end
      end
      ST_GATE: begin
        if (sub == 3'd2) begin
          sub_next   = '0;
          state_next = status.gate_fail ? ST_IDLE : ST_UPD2;
        end
      end
      ST_UPD2: begin
        if (sub == 3'd4) begin
          sub_next  = '0;
          axis_next = axis + 2'd1;
          if (axis == LAST_AXIS) begin
            axis_next  = '0;
            state_next = ST_ACCEPT;
          end
        end
      end
      ST_ACCEPT: begin
        cmd.uop.op = OP_ACCEPT;
        state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.uop.op = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### design/gated_constant_velocity_kalman_3d.sv
// Top level of the gated three-axis constant-velocity tracker.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+--------------------------------------
//   in       | in_valid / in_ready  | in_data  (cmd, meas_x/y/z, now_ms)
//   out      | out_valid / out_ready| out_data (est_pos_x..z, est_vel_x..z)
//   cfg      | cfg_we               | cfg_index, cfg_data
//
// One request at a time. A predicting tick runs decide, precompute, the predict
// steps of each axis and emit, on the single shared 32x32 multiplier. A measurement
// update is paced by the bit-serial divider (48 quotient bits per gain, two gains
// per axis). Dropped ticks and reset measurements end at decide, gated measurements
// at the gate. Reset is synchronous, no clearing pass. A tick waits only for the
// result register to drain.
`timescale 1ns / 1ps
module gated_constant_velocity_kalman_3d
  import gcvk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer: decide what a request does, then step its microprogram.
  gcvk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: filter state, arithmetic and the result register.
  gcvk_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`include "gated_constant_velocity_kalman_3d_assert.svh"

  // Hold off new requests while one is in flight.
  `GCVK_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "request accepted while busy")
  // Load a result only into a free register.
  `GCVK_ASSERT_NOW(a_emit_free, clk, rst, cmd.uop.op == OP_EMIT, status.out_free, "result overwrote a waiting one")
  // A result appears only from an emit step.
  `GCVK_ASSERT_NOW(a_valid_from_emit, clk, rst, $rose(out_valid), $past(cmd.uop.op == OP_EMIT), "result without emit")

endmodule
